/* sv/linear_interp_resampler_unit_defines.svh */
// ---------------------------------------------------------------------------
// Linear interpolation resampler: assertion macros
// Shared property forms for the resampler checker. Each use expects clk and
// rst_n to be visible in the calling scope.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lirs_pkg.sv */
// ---------------------------------------------------------------------------
// Linear interpolation resampler: shared package
// Sequencer states, configuration register indexes and the control and
// status bundles exchanged between the sequencer and the datapath.
// ---------------------------------------------------------------------------
package lirs_pkg;

  localparam int CFG_IDX_BITS = 2;
  localparam int CH_CNT_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_CH     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DST_CH     = 2'd2;

  localparam logic [CH_CNT_BITS-1:0] CH_MONO   = 2'd1;
  localparam logic [CH_CNT_BITS-1:0] CH_STEREO = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_UNITY,
    ST_MUL0,
    ST_MUL1,
    ST_PUSH,
    ST_FINISH
  } state_t;

  // Status reported by the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic unity;
    logic primed;
    logic below_one;
    logic run_end;
    logic out_free;
  } stat_t;

  // Strobes issued by the sequencer to the datapath.
  typedef struct packed {
    logic ready;
    logic map_en;
    logic mul_en;
    logic mul_sel;
    logic res0_en;
    logic push;
    logic push_unity;
    logic finish;
  } ctrl_t;

endpackage

/* sv/linear_interp_resampler_unit.sv */
// ---------------------------------------------------------------------------
// Linear interpolation resampler
// Channel-maps each audio frame and emits linearly interpolated output frames
// at the rate set by a fractional phase step, using one shared multiplier.
// ---------------------------------------------------------------------------
// Usage. Input requests arrive on in_valid/in_stall with two signed samples;
// in_stall is high whenever the block is working on a frame. Output requests
// leave on out_valid/out_stall through a single output register, so a finished
// result may wait there while the block carries on or takes the next frame.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) and must
// only be written while the block is idle; writes take effect on the next
// frame. Indexes beyond the register list are ignored.
// Sequence. A frame is accepted while idle and mapped in the next cycle. With a
// step of exactly one the frame is copied out and the block then returns to
// idle. Otherwise each interpolated output takes two multiplies on the shared
// multiplier, one per channel, then the push, and the frame finishes with a
// phase-update step; a frame yields at most MAX_UPSAMPLE outputs. The first
// output follows the map, both multiplies and the push. A stalled receiver
// holds the sequencer at the push step, or at the copy for a step of one.
// Reset (synchronous, active low) restores the register defaults, clears the
// phase and previous frame, and makes the next frame a priming frame.
// ---------------------------------------------------------------------------
module linear_interp_resampler_unit #(
  parameter int SAMPLE_BITS  = 16,
  parameter int FRAC_BITS    = 20,
  parameter int MAX_UPSAMPLE = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lirs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FRAC_BITS+3:0]              cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_ch1,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_ch0,
  output logic signed [SAMPLE_BITS-1:0]     out_ch1,
  output logic                              out_last_of_run
);

  import lirs_pkg::*;

  localparam int STEP_W = FRAC_BITS + 4;
  // One guard bit above the Q4 integer part holds phase + step mid-run.
  localparam int PH_W   = FRAC_BITS + 5;
  localparam int CNT_W  = (MAX_UPSAMPLE > 1) ? $clog2(MAX_UPSAMPLE) : 1;

  localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0]   PHASE_ONE = PH_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_UPSAMPLE - 1);

  stat_t stat;
  ctrl_t ctrl;

  // Configuration registers.
  logic [STEP_W-1:0]      step_r;
  logic [CH_CNT_BITS-1:0] src_cnt_r;
  logic [CH_CNT_BITS-1:0] dst_cnt_r;

  // Frame state.
  logic signed [SAMPLE_BITS-1:0] in_a_r;
  logic signed [SAMPLE_BITS-1:0] in_b_r;
  logic signed [SAMPLE_BITS-1:0] cur0_r;
  logic signed [SAMPLE_BITS-1:0] cur1_r;
  logic signed [SAMPLE_BITS-1:0] prev0_r;
  logic signed [SAMPLE_BITS-1:0] prev1_r;
  logic                          primed_r;
  logic [PH_W-1:0]               phase_r;
  logic [PH_W-1:0]               phase_sum;
  logic [CNT_W-1:0]              cnt_r;
  logic signed [SAMPLE_BITS-1:0] res0_r;

  // Channel mapping.
  logic                          src_mono;
  logic                          dst_mono;
  logic signed [SAMPLE_BITS:0]   pair_sum;
  logic signed [SAMPLE_BITS-1:0] map0;
  logic signed [SAMPLE_BITS-1:0] map1;

  // Shared interpolation unit.
  logic signed [SAMPLE_BITS-1:0] mac_base;
  logic signed [SAMPLE_BITS-1:0] mac_target;
  logic signed [SAMPLE_BITS-1:0] mac_res;

  // Output register.
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_ch0_r;
  logic signed [SAMPLE_BITS-1:0] out_ch1_r;
  logic                          out_last_r;
  logic                          out_free;

  // A channel count of one is mono; every other code is treated as stereo.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_ONE;
      src_cnt_r <= CH_STEREO;
      dst_cnt_r <= CH_STEREO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP: step_r    <= cfg_wdata;
        CFG_SRC_CH:     src_cnt_r <= cfg_wdata[CH_CNT_BITS-1:0];
        CFG_DST_CH:     dst_cnt_r <= cfg_wdata[CH_CNT_BITS-1:0];
        default:        ;
      endcase
    end
  end

  assign in_stall = !ctrl.ready;

  always_ff @(posedge clk) begin
    if (in_valid && ctrl.ready) begin
      in_a_r <= in_sample_ch0;
      in_b_r <= in_sample_ch1;
    end
  end

  // Stereo to mono floors the halved sum; the arithmetic drop of the low bit
  // does exactly that for negative sums too.
  assign src_mono = (src_cnt_r == CH_MONO);
  assign dst_mono = (dst_cnt_r == CH_MONO);
  assign pair_sum = (SAMPLE_BITS + 1)'(in_a_r) + (SAMPLE_BITS + 1)'(in_b_r);

  always_comb begin
    if (dst_mono) begin
      map0 = src_mono ? in_a_r : $signed(pair_sum[SAMPLE_BITS:1]);
      map1 = '0;
    end else begin
      map0 = in_a_r;
      map1 = src_mono ? in_a_r : in_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.map_en) begin
      cur0_r <= map0;
      cur1_r <= map1;
    end
  end

  // Within the run the phase is below one, so its low bits are the fraction.
  assign mac_base   = ctrl.mul_sel ? prev1_r : prev0_r;
  assign mac_target = ctrl.mul_sel ? cur1_r  : cur0_r;

  lirs_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .mul_en (ctrl.mul_en),
    .base   (mac_base),
    .target (mac_target),
    .frac   (phase_r[FRAC_BITS-1:0]),
    .result (mac_res)
  );

  always_ff @(posedge clk) begin
    if (ctrl.res0_en) begin
      res0_r <= mac_res;
    end
  end

  assign phase_sum = phase_r + PH_W'(step_r);

  // The priming frame leaves the phase untouched; the phase is always zero
  // before the first frame after reset, so the common finish step serves it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev0_r  <= '0;
      prev1_r  <= '0;
      primed_r <= 1'b0;
      phase_r  <= '0;
      cnt_r    <= '0;
    end else begin
      if (ctrl.map_en) begin
        cnt_r <= '0;
      end
      if (ctrl.push) begin
        phase_r <= phase_sum;
        cnt_r   <= cnt_r + CNT_W'(1);
      end
      if (ctrl.push_unity || ctrl.finish) begin
        prev0_r  <= cur0_r;
        prev1_r  <= cur1_r;
        primed_r <= 1'b1;
      end
      // Still below one here means the output cap cut the run short or this is the
      // priming frame, and the phase restarts from zero.
      if (ctrl.finish) begin
        phase_r <= stat.below_one ? '0 : phase_r - PHASE_ONE;
      end
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.push || ctrl.push_unity) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      out_ch0_r  <= res0_r;
      out_ch1_r  <= mac_res;
      out_last_r <= stat.run_end;
    end else if (ctrl.push_unity) begin
      out_ch0_r  <= cur0_r;
      out_ch1_r  <= cur1_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ch0         = out_ch0_r;
  assign out_ch1         = out_ch1_r;
  assign out_last_of_run = out_last_r;

  // The run ends when the advanced phase reaches one or the cap is reached.
  always_comb begin
    stat           = '0;
    stat.in_fire   = in_valid && ctrl.ready;
    stat.unity     = (step_r == STEP_ONE);
    stat.primed    = primed_r;
    stat.below_one = (phase_r[PH_W-1:FRAC_BITS] == '0);
    stat.run_end   = (phase_sum[PH_W-1:FRAC_BITS] != '0) || (cnt_r == CNT_LAST);
    stat.out_free  = out_free;
  end

  lirs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

endmodule

/* sv/lirs_mac.sv */
// ---------------------------------------------------------------------------
// Linear interpolation resampler: shared interpolation unit
// Registers (target - base) * frac, then adds the floored, rescaled product
// back onto the base sample. One channel per multiply.
// ---------------------------------------------------------------------------
module lirs_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 20
) (
  input  logic                          clk,
  input  logic                          mul_en,
  input  logic signed [SAMPLE_BITS-1:0] base,
  input  logic signed [SAMPLE_BITS-1:0] target,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  logic signed [DIFF_W-1:0]      diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [SAMPLE_BITS-1:0] base_r;
  logic signed [PROD_W-1:0]      prod_shift;
  logic signed [SUM_W-1:0]       step_q;
  logic signed [SUM_W-1:0]       sum;

  assign diff     = DIFF_W'(target) - DIFF_W'(base);
  assign frac_s   = $signed({1'b0, frac});
  assign prod_nxt = diff * frac_s;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
      base_r <= base;
    end
  end

  // The arithmetic shift floors the scaled difference in both directions.
  assign prod_shift = prod_r >>> FRAC_BITS;
  assign step_q     = $signed(prod_shift[SUM_W-1:0]);
  assign sum        = SUM_W'(base_r) + step_q;
  assign result     = $signed(sum[SAMPLE_BITS-1:0]);

endmodule

/* sv/lirs_seq.sv */
// ---------------------------------------------------------------------------
// Linear interpolation resampler: sequencer
// Steps one input frame through mapping, the unity copy or the interpolation
// loop and end-of-frame phase update, issuing strobes to the datapath.
// ---------------------------------------------------------------------------
module lirs_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  lirs_pkg::stat_t stat,
  output lirs_pkg::ctrl_t ctrl
);

  import lirs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.in_fire) state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (stat.unity) begin
          state_nxt = ST_UNITY;
        end else if (stat.primed && stat.below_one) begin
          state_nxt = ST_MUL0;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_UNITY: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_MUL0:   state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (stat.out_free) state_nxt = stat.run_end ? ST_FINISH : ST_MUL0;
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.ready      = (state_r == ST_IDLE);
    ctrl.map_en     = (state_r == ST_MAP);
    ctrl.mul_en     = (state_r == ST_MUL0) || (state_r == ST_MUL1);
    ctrl.mul_sel    = (state_r == ST_MUL1);
    ctrl.res0_en    = (state_r == ST_MUL1);
    ctrl.push       = (state_r == ST_PUSH) && stat.out_free;
    ctrl.push_unity = (state_r == ST_UNITY) && stat.out_free;
    ctrl.finish     = (state_r == ST_FINISH);
  end

endmodule

/* sv/lirs_chk.sv */
// ---------------------------------------------------------------------------
// Linear interpolation resampler: port checker
// Watches the top-level channels over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "linear_interp_resampler_unit_defines.svh"

module lirs_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_ch0,
  input logic signed [SAMPLE_BITS-1:0] out_ch1,
  input logic                          out_last_of_run
);

  // A held result request keeps its payload until it is taken.
  `LIRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_ch0) && $stable(out_ch1) && $stable(out_last_of_run), "output request changed while stalled")

  // Every accepted frame keeps the block busy for at least the mapping cycle.
  `LIRS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block ready straight after an accepted frame")

  // The block only becomes busy because it accepted a frame.
  `LIRS_ASSERT_IMP(a_busy_cause, $rose(in_stall), $past(in_valid && !in_stall), "block went busy without an accepted frame")

endmodule

bind linear_interp_resampler_unit lirs_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_chk (.*);
